// ===== rtl/igpr_pkg.sv =====
// Package for the idle gap packet receiver.
// Holds the item and status types and the fixed field widths; no dependencies.
package igpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int GAP_W       = 16;
    localparam int LEN_W       = 7;
    localparam int IDLE_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDLE_W-1:0] IDLE_MAX    = 17'h1FFFF;
    localparam logic [GAP_W-1:0]  GAP_RESET   = 16'd1000;
    localparam logic [LEN_W-1:0]  LEN_RESET   = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT_LEN = 2'd1;

    typedef enum logic
    {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    typedef struct packed
    {
        item_kind_t        kind;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } back_state_t;

    typedef struct packed
    {
        logic [LEN_W-1:0] fill;
        logic [LEN_W-1:0] remain;
        logic             draining;
    } back_status_t;

endpackage

// ===== rtl/igpr_rx_if.sv =====
// Receive channel interface: one received byte or one time tick per word.
// Depends on igpr_pkg for the byte width.
interface igpr_rx_if;
    import igpr_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== rtl/igpr_pkt_if.sv =====
// Packet channel interface: one released byte per word with a last flag.
// Depends on igpr_pkg for the byte width.
interface igpr_pkt_if;
    import igpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/igpr_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
// Depends on igpr_pkg for the index and data widths.
interface igpr_cfg_if;
    import igpr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/idle_gap_packet_receiver.sv =====
// Top level of the idle gap packet receiver: configuration registers, front,
// queue and back stages. Depends on igpr_pkg, the three channel interfaces
// and the igpr_front, igpr_queue and igpr_back modules.
//
//  Port  Direction  Word contents
//  rx    in         cmd (0 byte, 1 tick), rx_byte
//  pkt   out        out_byte, out_last
//  cfg   in         addr (0 gap_ticks, 1 max_out_len), data
//
// The receive side takes one word per cycle while the four-entry queue has room.
// The back stage retires one byte or tick item per cycle while it is idle; a
// released packet holds it until drained, each byte going first through the
// buffer memory read and then the output register load. The output register
// holds its word while pkt is stalled. After reset the block is ready at once;
// the buffer memory is not cleared because only written entries are ever read.
module idle_gap_packet_receiver
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    igpr_rx_if.sink    rx,
    igpr_pkt_if.source pkt,
    igpr_cfg_if.sink   cfg
);
    import igpr_pkg::*;

    logic [GAP_W-1:0] gap_reg;
    logic [GAP_W-1:0] gap_next;
    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] max_len_next;
    logic             cfg_we;

    logic             push;
    item_t            push_item;
    logic             queue_full;
    logic             pop;
    logic             pop_valid;
    item_t            pop_item;
    back_status_t     status;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_comb
    begin
        gap_next     = gap_reg;
        max_len_next = max_len_reg;
        if (cfg_we)
        begin
            case (cfg.addr)
                CFG_GAP_TICKS:
                begin
                    gap_next = cfg.data;
                end
                CFG_MAX_OUT_LEN:
                begin
                    max_len_next = cfg.data[LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= GAP_RESET;
            max_len_reg <= LEN_RESET;
        end
        else
        begin
            gap_reg     <= gap_next;
            max_len_reg <= max_len_next;
        end
    end

    igpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_cmd     (rx.cmd),
        .in_byte    (rx.rx_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    igpr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    igpr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pop_valid),
        .item        (pop_item),
        .item_pop    (pop),
        .gap_ticks   (gap_reg),
        .max_out_len (max_len_reg),
        .out_valid   (pkt.valid),
        .out_ready   (pkt.ready),
        .out_byte    (pkt.out_byte),
        .out_last    (pkt.out_last),
        .status      (status)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill <= LEN_W'(BUFFER_DEPTH))
        else $error("Buffer fill count exceeds the buffer depth.");

    a_drain_remain: assert property (@(posedge clk) disable iff (!rst_n)
        status.draining |-> (status.remain != '0) && (status.remain <= status.fill))
        else $error("Packet drain has no bytes left to send.");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.out_last && !$past(pkt.valid && pkt.ready) && $rose(pkt.valid))
        |-> !status.draining)
        else $error("Last byte loaded while the drain is still running.");

    a_cfg_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && (cfg.addr == CFG_GAP_TICKS)) |=> gap_reg == $past(cfg.data))
        else $error("Gap setting did not take the written value.");

endmodule

// ===== rtl/igpr_front.sv =====
// Front stage: accepts receive words, classifies them as byte or tick items
// and holds one item until the queue takes it. Depends on igpr_pkg.
module igpr_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_cmd,
    input  logic [igpr_pkg::BYTE_W-1:0] in_byte,
    output logic                  push,
    output igpr_pkg::item_t       push_item,
    input  logic                  queue_full
);
    import igpr_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  take;

    assign push      = stage_valid_reg && !queue_full;
    assign in_ready  = !stage_valid_reg || !queue_full;
    assign take      = in_valid && in_ready;
    assign push_item = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.kind <= in_cmd ? KIND_TICK : KIND_BYTE;
            stage_item_reg.data <= in_byte;
        end
    end

endmodule

// ===== rtl/igpr_queue.sv =====
// Short item queue between the front and back stages.
// Depends on igpr_pkg for the item type and queue depth.
module igpr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  igpr_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output igpr_pkg::item_t pop_item
);
    import igpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/igpr_back.sv =====
// Back stage: byte buffer held as a ring in memory, idle counter, gap check
// and packet drain into the output register. Depends on igpr_pkg.
module igpr_back
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  igpr_pkg::item_t              item,
    output logic                         item_pop,
    input  logic [igpr_pkg::GAP_W-1:0]   gap_ticks,
    input  logic [igpr_pkg::LEN_W-1:0]   max_out_len,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [igpr_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_last,
    output igpr_pkg::back_status_t       status
);
    import igpr_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              is_byte;
    logic              is_tick;
    logic              buf_full;
    logic              gap_hit;
    logic [LEN_W-1:0]  fill_ext;
    logic [LEN_W-1:0]  pkt_len;
    logic [SUM_W-1:0]  wr_sum;
    logic [PTR_W-1:0]  wr_addr;
    logic              wr_en;
    logic              rd_en;
    logic              load;

    assign item_pop = (state_reg == BK_IDLE) && item_valid;
    assign is_byte  = item_pop && (item.kind == KIND_BYTE);
    assign is_tick  = item_pop && (item.kind == KIND_TICK) && (fill_reg != '0);
    assign buf_full = (fill_reg == CNT_W'(BUFFER_DEPTH));
    assign gap_hit  = (idle_reg > IDLE_W'(gap_ticks));
    assign fill_ext = LEN_W'(fill_reg);
    assign pkt_len  = (fill_ext <= max_out_len) ? fill_ext : max_out_len;
    assign wr_sum   = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign wr_addr  = (wr_sum >= SUM_W'(BUFFER_DEPTH)) ?
                      PTR_W'(wr_sum - SUM_W'(BUFFER_DEPTH)) : PTR_W'(wr_sum);
    assign wr_en    = is_byte && !buf_full;
    assign rd_en    = (state_reg == BK_READ);
    assign load     = (state_reg == BK_LOAD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (is_tick && gap_hit && (pkt_len != '0))
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (load)
                begin
                    state_next = (remain_reg == CNT_W'(1)) ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        head_next      = head_reg;
        idle_next      = idle_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (wr_en)
                begin
                    fill_next = fill_reg + 1'b1;
                    idle_next = '0;
                end
                else if (is_tick)
                begin
                    if (gap_hit)
                    begin
                        idle_next   = '0;
                        remain_next = CNT_W'(pkt_len);
                    end
                    else if (idle_reg != IDLE_MAX)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
            end
            BK_LOAD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    fill_next      = fill_reg - 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    head_next      = (head_reg == PTR_W'(BUFFER_DEPTH - 1)) ?
                                     '0 : head_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            idle_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            idle_reg      <= idle_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= (remain_reg == CNT_W'(1));
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_last        = out_last_reg;
    assign status.fill     = LEN_W'(fill_reg);
    assign status.remain   = LEN_W'(remain_reg);
    assign status.draining = (state_reg != BK_IDLE);

endmodule
